// ----- rtl/stsi_pkg.sv -----
package stsi_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int KIND_W           = 2;
    localparam int INDEX_W          = 6;
    localparam int OUT_W            = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_UPDATE = 2'd2
    } t_kind;

    // commands from sequencer to datapath
    typedef struct packed {
        logic load;
        logic rd_mid;
        logic srch_step;
        logic res_miss;
        logic res_full;
        logic rd_swap;
        logic wr_swap_lo;
        logic wr_swap_hi;
        logic app_wr;
        logic ins_rd;
        logic ins_shift;
        logic ins_wr;
        logic res_load;
    } t_cmd;

    // datapath status back to sequencer
    typedef struct packed {
        logic full;
        logic srch_end;
        logic eq;
        logic lt;
        logic hit_last;
        logic slot_zero;
        logic slot_one;
    } t_stat;

endpackage

// ----- rtl/stsi_dp.sv -----
module stsi_dp #(
    parameter int CAPACITY = stsi_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stsi_pkg::t_cmd                i_cmd,
    input  logic [stsi_pkg::VALUE_W-1:0]  i_value,
    output stsi_pkg::t_stat               o_stat,
    output logic                          o_found,
    output logic [stsi_pkg::INDEX_W-1:0]  o_index,
    output logic                          o_status
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int VW = stsi_pkg::VALUE_W;
    localparam int IW = stsi_pkg::INDEX_W;

    logic signed [VW-1:0] r_mem [CAPACITY];
    logic signed [VW-1:0] r_rdata;
    logic signed [VW-1:0] r_value;
    logic [FW-1:0]        r_fill;
    logic [FW-1:0]        r_lo;
    logic [FW-1:0]        r_hi;       // exclusive upper bound
    logic [FW-1:0]        r_slot;
    logic                 r_res_found;
    logic [IW-1:0]        r_res_index;
    logic                 r_res_status;
    logic                 r_out_found;
    logic [IW-1:0]        r_out_index;
    logic                 r_out_status;

    logic [FW:0]          mid_sum;
    logic [FW-1:0]        mid;
    logic [FW-1:0]        lo_inc;
    logic [FW:0]          lo_inc_w;
    logic [FW-1:0]        slot_dec;
    logic [FW-1:0]        slot_dec2;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [VW-1:0] wdata;
    logic                 re;
    logic [AW-1:0]        raddr;

    // floor((lo + hi_incl) / 2), only used while lo < hi
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi} - (FW+1)'(1);
    assign mid       = mid_sum[FW:1];
    assign lo_inc_w  = {1'b0, r_lo} + (FW+1)'(1);
    assign lo_inc    = lo_inc_w[FW-1:0];
    assign slot_dec  = r_slot - FW'(1);
    assign slot_dec2 = r_slot - FW'(2);

    assign o_stat.full      = (r_fill == FW'(CAPACITY));
    assign o_stat.srch_end  = (r_lo >= r_hi);
    assign o_stat.eq        = (r_rdata == r_value);
    assign o_stat.lt        = (r_rdata < r_value);
    assign o_stat.hit_last  = (lo_inc_w >= {1'b0, r_fill});
    assign o_stat.slot_zero = (r_slot == '0);
    assign o_stat.slot_one  = (r_slot == FW'(1));

    always_comb begin
        we    = i_cmd.app_wr | i_cmd.wr_swap_lo | i_cmd.wr_swap_hi
              | i_cmd.ins_shift | i_cmd.ins_wr;
        waddr = r_slot[AW-1:0];
        wdata = r_value;
        if (i_cmd.app_wr) begin
            waddr = r_fill[AW-1:0];
        end else if (i_cmd.wr_swap_lo) begin
            waddr = r_lo[AW-1:0];
            wdata = r_rdata;
        end else if (i_cmd.wr_swap_hi) begin
            waddr = lo_inc[AW-1:0];
        end else if (i_cmd.ins_shift) begin
            wdata = r_rdata;
        end

        // next probe below the shifted slot goes out in the same cycle
        re    = i_cmd.rd_mid | i_cmd.rd_swap | i_cmd.ins_rd
              | (i_cmd.ins_shift & ~o_stat.slot_one);
        raddr = slot_dec2[AW-1:0];
        if (i_cmd.rd_mid) begin
            raddr = mid[AW-1:0];
        end else if (i_cmd.rd_swap) begin
            raddr = lo_inc[AW-1:0];
        end else if (i_cmd.ins_rd) begin
            raddr = slot_dec[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.app_wr || i_cmd.ins_wr) begin
            r_fill <= r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value      <= i_value;
            r_lo         <= '0;
            r_hi         <= r_fill;
            r_slot       <= r_fill;
            r_res_found  <= 1'b0;
            r_res_index  <= '0;
            r_res_status <= 1'b0;
        end
        if (i_cmd.srch_step) begin
            if (o_stat.eq) begin
                r_lo        <= mid;
                r_res_found <= 1'b1;
                r_res_index <= IW'(mid);
            end else if (o_stat.lt) begin
                r_lo <= mid + FW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.res_miss) begin
            r_res_index <= IW'(r_lo);
        end
        if (i_cmd.res_full) begin
            r_res_status <= 1'b1;
        end
        if (i_cmd.app_wr) begin
            r_res_index <= IW'(r_fill);
        end
        if (i_cmd.ins_shift) begin
            r_slot <= slot_dec;
        end
        if (i_cmd.ins_wr) begin
            r_res_index <= IW'(r_slot);
        end
        if (i_cmd.res_load) begin
            r_out_found  <= r_res_found;
            r_out_index  <= r_res_index;
            r_out_status <= r_res_status;
        end
    end

    assign o_found  = r_out_found;
    assign o_index  = r_out_index;
    assign o_status = r_out_status;

endmodule

// ----- rtl/stsi_ctrl.sv -----
module stsi_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [stsi_pkg::KIND_W-1:0]  i_kind,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  stsi_pkg::t_stat              i_stat,
    output stsi_pkg::t_cmd               o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HIT,
        ST_SWAP_RD,
        ST_SWAP_LO,
        ST_SWAP_HI,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_RESULT
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [stsi_pkg::KIND_W-1:0]  r_kind;
    logic                         r_out_valid;
    logic                         accept;
    logic                         update;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign update     = (r_kind == stsi_pkg::KIND_UPDATE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_kind)
                        stsi_pkg::KIND_APPEND: n_state = ST_APPEND;
                        stsi_pkg::KIND_SEARCH: n_state = ST_SRCH_RD;
                        stsi_pkg::KIND_UPDATE: n_state = ST_SRCH_RD;
                        default:               n_state = ST_RESULT;
                    endcase
                end
            end
            ST_APPEND: begin
                if (i_stat.full) begin
                    o_cmd.res_full = 1'b1;
                end else begin
                    o_cmd.app_wr = 1'b1;
                end
                n_state = ST_RESULT;
            end
            ST_SRCH_RD: begin
                if (i_stat.srch_end) begin
                    if (!update) begin
                        o_cmd.res_miss = 1'b1;
                        n_state = ST_RESULT;
                    end else if (i_stat.full) begin
                        o_cmd.res_full = 1'b1;
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                o_cmd.srch_step = 1'b1;
                n_state = i_stat.eq ? ST_HIT : ST_SRCH_RD;
            end
            ST_HIT: begin
                n_state = (update && !i_stat.hit_last) ? ST_SWAP_RD : ST_RESULT;
            end
            ST_SWAP_RD: begin
                o_cmd.rd_swap = 1'b1;
                n_state = ST_SWAP_LO;
            end
            ST_SWAP_LO: begin
                o_cmd.wr_swap_lo = 1'b1;
                n_state = ST_SWAP_HI;
            end
            ST_SWAP_HI: begin
                o_cmd.wr_swap_hi = 1'b1;
                n_state = ST_RESULT;
            end
            ST_INS_RD: begin
                if (i_stat.slot_zero) begin
                    n_state = ST_INS_WR;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                // entry below the slot is larger: move it up one place
                if (!i_stat.eq && !i_stat.lt) begin
                    o_cmd.ins_shift = 1'b1;
                    if (i_stat.slot_one) begin
                        n_state = ST_INS_WR;
                    end
                end else begin
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.res_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_kind <= i_kind;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start an operation");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_m_tready))
        else $error("pending result overwritten");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.app_wr || o_cmd.ins_wr) |-> !i_stat.full)
        else $error("write past table capacity");

    a_shift_above_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ins_shift |-> !i_stat.slot_zero)
        else $error("insert shift below index zero");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_mid |-> !i_stat.srch_end)
        else $error("search probe with empty range");
`endif

endmodule

// ----- rtl/sorted_table_search_insert_unit.sv -----
// append writes the value at the end of the table; kind 3 performs no operation and returns a zeroed result
// search: binary search, with a read state and a compare state per probe
// update hit swaps the entry with the one above it (read, write low, write high); sorted insert moves
// each larger entry up one place (one read port and one write port, one access of each per cycle)
// one item at a time; the next beat is taken once the result is registered
// synchronous active-low reset empties the table (fill count only, no sweep)
module sorted_table_search_insert_unit #(
    parameter int CAPACITY = stsi_pkg::DEFAULT_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [stsi_pkg::VALUE_W-1:0] i_s_tdata,   // [31:0] value
    input  logic [stsi_pkg::KIND_W-1:0]  i_s_tuser,   // [1:0] kind
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [stsi_pkg::OUT_W-1:0]   o_m_tdata    // [0] found, [6:1] index, [7] status
);

    stsi_pkg::t_cmd                 cmd;
    stsi_pkg::t_stat                stat;
    logic                           found;
    logic [stsi_pkg::INDEX_W-1:0]   index;
    logic                           status;

    stsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_kind     (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stsi_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_s_tdata),
        .o_stat   (stat),
        .o_found  (found),
        .o_index  (index),
        .o_status (status)
    );

    assign o_m_tdata = {status, index, found};

endmodule
